FILE: rtl/core/rlab_pkg.sv
// ----------------------------------------------------------------------------
// rlab_pkg
// Shared types and constants for the reverse loop audio buffer.
// ----------------------------------------------------------------------------
package rlab_pkg;

	localparam int SAMPLE_BITS       = 16;
	localparam int STORE_DEPTH_DEF   = 262144;
	localparam int CFG_INDEX_W       = 2;
	localparam int CFG_DATA_W        = 19;
	localparam int LOOP_LENGTH_RESET = 24000;

	localparam int CRUNCH_SHIFT = (SAMPLE_BITS > 12) ? SAMPLE_BITS - 12 : 0;
	localparam logic [SAMPLE_BITS-1:0] CRUNCH_MASK =
		~((SAMPLE_BITS'(1) << CRUNCH_SHIFT) - SAMPLE_BITS'(1));

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LOOP_LENGTH   = 2'd0,
		CFG_CRUNCH_ENABLE = 2'd1
	} cfg_index_t;

	typedef struct packed {
		logic                          trigger;
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
	} result_t;

	// per-item controls from the address stage to the read stage
	typedef struct packed {
		logic wr;
		logic rd;
		logic blank;
		logic crunch;
	} rlab_ctl_t;

endpackage

FILE: rtl/core/rlab_ram.sv
// ----------------------------------------------------------------------------
// rlab_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlab_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/rlab_ctrl.sv
// ----------------------------------------------------------------------------
// rlab_ctrl
// Configuration registers, trigger tracking and store address generation.
// ----------------------------------------------------------------------------
module rlab_ctrl import rlab_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	localparam int AW = $clog2(STORE_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   accept,
	input  logic                   trigger,
	output logic [AW-1:0]          addr,
	output rlab_ctl_t              ctl
);

	localparam int LW = (AW + 1 > CFG_DATA_W) ? AW + 1 : CFG_DATA_W;
	localparam int LEN_RESET = (LOOP_LENGTH_RESET < STORE_DEPTH) ?
		LOOP_LENGTH_RESET : STORE_DEPTH;

	logic [AW:0]   eff_len_q;
	logic          crunch_q;
	logic [AW-1:0] wp_q;
	logic          wrapped_q;
	logic [AW-1:0] rstart_q;
	logic [AW-1:0] off_q;
	logic          rev_q;
	logic          prev_q;

	logic          rise;
	logic          rev_next;
	logic [AW-1:0] rstart_new;
	logic [AW-1:0] start;
	logic [AW-1:0] off;
	logic [AW:0]   diff;
	logic [AW:0]   pos_w;
	logic [AW-1:0] pos;
	logic [AW:0]   off_inc;
	logic [AW-1:0] off_next;
	logic [LW-1:0] len_in;
	logic [AW:0]   len_new;

	assign rise       = trigger && !prev_q;
	assign rev_next   = rise || (trigger && rev_q);
	assign rstart_new = (wp_q == '0) ? AW'(STORE_DEPTH - 1) : wp_q - AW'(1);
	assign start      = rise ? rstart_new : rstart_q;
	assign off        = (rise || ({1'b0, off_q} >= eff_len_q)) ? '0 : off_q;
	assign diff       = {1'b0, start} - {1'b0, off};
	assign pos_w      = diff[AW] ? diff + (AW + 1)'(STORE_DEPTH) : diff;
	assign pos        = pos_w[AW-1:0];
	assign off_inc    = {1'b0, off} + (AW + 1)'(1);
	assign off_next   = (off_inc >= eff_len_q) ? '0 : off_inc[AW-1:0];

	assign len_in  = LW'(cfg_data);
	assign len_new = (len_in == '0) ? (AW + 1)'(1) :
		(len_in > LW'(STORE_DEPTH)) ? (AW + 1)'(STORE_DEPTH) : len_in[AW:0];

	assign addr       = rev_next ? pos : wp_q;
	assign ctl.wr     = accept && !rev_next;
	assign ctl.rd     = accept && rev_next;
	assign ctl.blank  = !wrapped_q && (pos >= wp_q);
	assign ctl.crunch = crunch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_len_q <= (AW + 1)'(LEN_RESET);
			crunch_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LOOP_LENGTH:   eff_len_q <= len_new;
				CFG_CRUNCH_ENABLE: crunch_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			rstart_q  <= '0;
			off_q     <= '0;
			rev_q     <= 1'b0;
			prev_q    <= 1'b0;
		end else if (accept) begin
			prev_q <= trigger;
			rev_q  <= rev_next;
			if (rise) begin
				rstart_q <= rstart_new;
			end
			if (rev_next) begin
				off_q <= off_next;
			end else if (wp_q == AW'(STORE_DEPTH - 1)) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + AW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/reverse_loop_audio_buffer_core.sv
// ----------------------------------------------------------------------------
// reverse_loop_audio_buffer_core
// Stereo reverse stutter loop: records pairs into a ring store while the
// trigger is low, plays the last loop_length pairs backwards while it is high.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------
//  sample  | sample_valid/_stall     | sample (trigger, left_in, right_in)
//  result  | result_valid/_stall     | result (left_out, right_out)
//  cfg     | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
//  One item per cycle while the output is not stalled; items pass the store read stage, then the output register.
//  Store reads and writes share one pair-wide RAM; one access per item.
//  Unwritten entries read as zero through a wrap flag, so no clearing pass.
//  sample_stall rises only while the output register is full and stalled
//  and the read stage holds an item.
// ----------------------------------------------------------------------------
module reverse_loop_audio_buffer_core import rlab_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  sample_t                sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int DW = 2 * SAMPLE_BITS;

	logic          accept;
	logic          advance;
	logic          out_adv;
	logic [AW-1:0] addr;
	rlab_ctl_t     ctl;
	logic [DW-1:0] rdata;

	logic          valid_s1;
	logic          rev_s1;
	logic          blank_s1;
	logic          crunch_s1;
	logic [DW-1:0] data_s1;

	logic          out_valid_q;
	result_t       out_q;

	logic [DW-1:0] sel;
	logic [DW-1:0] mask;

	assign cfg_ready    = 1'b1;
	assign out_adv      = !out_valid_q || !result_stall;
	assign advance      = !valid_s1 || out_adv;
	assign sample_stall = !advance;
	assign accept       = sample_valid && advance;

	rlab_ctrl #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.trigger   (sample.trigger),
		.addr      (addr),
		.ctl       (ctl)
	);

	rlab_ram #(
		.WIDTH(DW),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ctl.wr),
		.waddr (addr),
		.wdata ({sample.left_in, sample.right_in}),
		.re    (ctl.rd),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rev_s1    <= ctl.rd;
			blank_s1  <= ctl.blank;
			crunch_s1 <= ctl.crunch;
			data_s1   <= {sample.left_in, sample.right_in};
		end
	end

	assign mask = crunch_s1 ? {CRUNCH_MASK, CRUNCH_MASK} : '1;
	assign sel  = !rev_s1 ? data_s1 : (blank_s1 ? '0 : (rdata & mask));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			out_q <= result_t'(sel);
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTH
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.wr && ctl.rd))
		else $error("store read and write issued for one item");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("input stalled without a blocked output");

	a_read_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(sel)))
		else $error("read stage item lost while stalled");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.wr || ctl.rd) |-> ((AW + 1)'(addr) < (AW + 1)'(STORE_DEPTH)))
		else $error("store address out of range");
`endif

endmodule

FILE: bench/rlab_reverse_checker.sv
// ----------------------------------------------------------------------------
// rlab_reverse_checker
// Watches the sample, result and cfg channels of the reverse loop buffer.
// Keeps its own ring stores and loop state, works out the stereo pair each
// accepted sample item should produce, and compares results in order.
// ----------------------------------------------------------------------------
module rlab_reverse_checker import rlab_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	input  logic                   sample_stall,
	input  sample_t                sample,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  result_t                result,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending
);

	localparam int unsigned DEPTH = STORE_DEPTH_DEF;
	// floor to 1/2048 full scale: keep the top 12 bits
	localparam logic [SAMPLE_BITS-1:0] CRUNCH_KEEP = 16'hFFF0;

	bit [SAMPLE_BITS-1:0] left_mem  [DEPTH];
	bit [SAMPLE_BITS-1:0] right_mem [DEPTH];

	int unsigned          wr_pos;
	int unsigned          rev_base;
	int unsigned          loop_ofs;
	bit                   rev_active;
	bit                   prev_trig;
	logic [CFG_DATA_W-1:0] loop_len;
	bit                   crunch_on;

	result_t expected_pairs [$];

	function automatic result_t predict_pair(sample_t s);
		result_t     r;
		int unsigned len;
		int unsigned off;
		int unsigned pos;
		logic [SAMPLE_BITS-1:0] l;
		logic [SAMPLE_BITS-1:0] rr;
		if (s.trigger && !prev_trig) begin
			rev_active = 1'b1;
			loop_ofs   = 0;
			rev_base   = (wr_pos > 0) ? wr_pos - 1 : DEPTH - 1;
		end else if (!s.trigger) begin
			rev_active = 1'b0;
		end
		prev_trig = s.trigger;
		if (!rev_active) begin
			left_mem[wr_pos]  = s.left_in;
			right_mem[wr_pos] = s.right_in;
			wr_pos = (wr_pos + 1 >= DEPTH) ? 0 : wr_pos + 1;
			r.left_out  = s.left_in;
			r.right_out = s.right_in;
		end else begin
			len = 32'(loop_len);
			if (len < 1)
				len = 1;
			if (len > DEPTH)
				len = DEPTH;
			off = (loop_ofs < len) ? loop_ofs : 0;
			pos = (rev_base >= off) ? rev_base - off : rev_base + DEPTH - off;
			l  = left_mem[pos];
			rr = right_mem[pos];
			if (crunch_on) begin
				l  = l & CRUNCH_KEEP;
				rr = rr & CRUNCH_KEEP;
			end
			r.left_out  = l;
			r.right_out = rr;
			loop_ofs = (off + 1 >= len) ? 0 : off + 1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			fail_count = 0;
			wr_pos     = 0;
			rev_base   = 0;
			loop_ofs   = 0;
			rev_active = 1'b0;
			prev_trig  = 1'b0;
			loop_len   = CFG_DATA_W'(LOOP_LENGTH_RESET);
			crunch_on  = 1'b0;
			expected_pairs.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LOOP_LENGTH:   loop_len  = cfg_data;
					CFG_CRUNCH_ENABLE: crunch_on = cfg_data[0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall)
				expected_pairs.push_back(predict_pair(sample));
			if (result_valid && !result_stall) begin
				if (expected_pairs.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, actual %h/%h",
						$time, result.left_out, result.right_out);
				end else begin
					want = expected_pairs.pop_front();
					if (result.left_out !== want.left_out) begin
						fail_count++;
						$display("%0t: left_out mismatch, expected %h, actual %h",
							$time, want.left_out, result.left_out);
					end
					if (result.right_out !== want.right_out) begin
						fail_count++;
						$display("%0t: right_out mismatch, expected %h, actual %h",
							$time, want.right_out, result.right_out);
					end
				end
			end
		end
		pending = expected_pairs.size();
	end

endmodule

FILE: bench/reverse_loop_audio_buffer_core_tb.sv
// ----------------------------------------------------------------------------
// reverse_loop_audio_buffer_core_tb
// Drives sample items and register writes into the reverse loop buffer:
// a directed opening over loop wrap, lowered length, zero and oversized
// lengths, crunch and ignored indexes, then random record/reverse bursts
// under four idle/stall patterns. The checker judges every result.
// ----------------------------------------------------------------------------
module reverse_loop_audio_buffer_core_tb;
	import rlab_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   sample_valid;
	logic                   sample_stall;
	sample_t                sample;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_t                result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int reversed_sent = 0;
	int reg_writes = 0;
	int quiet_cycles = 0;
	int burst_left = 0;
	bit burst_trig = 1'b1;

	reverse_loop_audio_buffer_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	rlab_reverse_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
			    (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic send_pair(input logic trig, input logic [SAMPLE_BITS-1:0] l,
	                         input logic [SAMPLE_BITS-1:0] r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid     <= 1'b1;
		sample.trigger   <= trig;
		sample.left_in   <= l;
		sample.right_in  <= r;
		do @(posedge clk); while (sample_stall);
		items_sent++;
		if (trig)
			reversed_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	initial begin
		logic                  trig;
		logic [CFG_DATA_W-1:0] len;
		sample_valid = 1'b0;
		sample       = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_LOOP_LENGTH;
		cfg_data     = '0;
		arst_n       = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// reverse before anything is recorded: reads from the last slot
		send_pair(1'b1, 16'h7FFF, 16'h8000);
		drain();
		write_reg(CFG_LOOP_LENGTH, 19'd4);
		write_reg(CFG_CRUNCH_ENABLE, 19'd0);
		send_pair(1'b0, 16'h7FFF, 16'h8000);
		send_pair(1'b0, 16'h8000, 16'h7FFF);
		send_pair(1'b0, 16'hFFFF, 16'h0001);
		send_pair(1'b0, 16'h0000, 16'hFFFF);
		send_pair(1'b0, 16'h123F, 16'hABCD);
		repeat (6)
			send_pair(1'b1, pick_sample(), pick_sample());
		// shorten the loop while still reversing
		drain();
		write_reg(CFG_LOOP_LENGTH, 19'd2);
		repeat (3)
			send_pair(1'b1, pick_sample(), pick_sample());
		send_pair(1'b0, 16'h8ACF, 16'h7531);
		// zero length holds one pair, crunched
		drain();
		write_reg(CFG_LOOP_LENGTH, 19'd0);
		write_reg(CFG_CRUNCH_ENABLE, 19'h7FFFF);
		repeat (3)
			send_pair(1'b1, pick_sample(), pick_sample());
		// length beyond the store, crunch off via bit 0, writes to unused indexes
		drain();
		write_reg(CFG_LOOP_LENGTH, 19'h7FFFF);
		write_reg(CFG_CRUNCH_ENABLE, 19'h7FFFE);
		write_reg(CFG_SPARE_2, 19'd3);
		write_reg(CFG_SPARE_3, 19'h7FFFF);
		send_pair(1'b0, 16'h5A5A, 16'hA5A5);
		repeat (4)
			send_pair(1'b1, pick_sample(), pick_sample());

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 85; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 85; end
				default: begin send_idle_pct = 16; stall_pct = 16; end
			endcase
			for (int half = 0; half < 2; half++) begin
				drain();
				case ($urandom_range(5))
					0: len = 19'd1;
					1: len = 19'd0;
					2: len = CFG_DATA_W'(STORE_DEPTH_DEF);
					3: len = 19'h7FFFF;
					default: len = CFG_DATA_W'($urandom_range(48, 2));
				endcase
				write_reg(CFG_LOOP_LENGTH, len);
				write_reg(CFG_CRUNCH_ENABLE, {18'($urandom), 1'($urandom_range(1))});
				if ($urandom_range(3) == 0)
					write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
				repeat (206) begin
					if (burst_left == 0) begin
						burst_trig = !burst_trig;
						burst_left = burst_trig ? $urandom_range(80, 1) : $urandom_range(60, 1);
					end
					burst_left--;
					trig = burst_trig;
					if ($urandom_range(9) == 0)
						trig = 1'($urandom_range(1));
					send_pair(trig, pick_sample(), pick_sample());
					if ($urandom_range(149) == 0)
						drain();
				end
			end
		end

		drain();
		repeat (8) @(negedge clk);
		$display("covered %0d sample items (%0d with trigger high) and %0d register writes",
			items_sent, reversed_sent, reg_writes);
		$display("under no idling, sender gaps, receiver stalls and both combined");
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/rlab_pkg.sv
rtl/core/rlab_ram.sv
rtl/core/rlab_ctrl.sv
rtl/core/reverse_loop_audio_buffer_core.sv
bench/rlab_reverse_checker.sv
bench/reverse_loop_audio_buffer_core_tb.sv
